[rtl/axd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axd_pkg
// Shared types and constants for the XOR archive stream deframer.
// ----------------------------------------------------------------------------
package axd_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int RUN_AW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RUN_DEPTH   = 1 << RUN_AW;
    localparam int COUNT_W     = RUN_AW + 1;
    localparam int ENTRY_W     = 8;
    localparam int SIZE_W      = 32;

    localparam logic [7:0]  KEY_RESET        = 8'hF7;
    localparam logic [31:0] ARCHIVE_MAGIC    = 32'hBAC04AC0;
    localparam logic [31:0] ARCHIVE_VERSION  = 32'h0000_0000;
    localparam logic [3:0]  MIN_STREAM_BYTES = 4'd10;

    localparam logic [7:0] MAGIC_BYTES  = 8'd4;
    localparam logic [7:0] HEADER_BYTES = 8'd8;
    localparam logic [7:0] SIZE_BYTES   = 8'd4;
    localparam logic [7:0] TIME_BYTES   = 8'd8;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FLAG,
        PH_NAMELEN,
        PH_NAME,
        PH_SIZE,
        PH_TIME,
        PH_DATA,
        PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER,
        KIND_INDEX,
        KIND_NAME,
        KIND_DATA,
        KIND_IGNORED
    } kind_t;

    typedef enum logic [2:0] {
        ST_RUNNING,
        ST_OK,
        ST_HEADER_BAD,
        ST_OVERFLOW,
        ST_LENGTH,
        ST_TRUNCATED
    } status_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        kind_t        byte_kind;
        logic [7:0]   decoded_byte;
        logic [7:0]   entry_number;
        logic         entry_final;
        status_t      status;
    } out_item_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry;
        logic [SIZE_W-1:0]  size;
    } run_t;

    typedef struct packed {
        logic              we;
        logic [RUN_AW-1:0] waddr;
        run_t              wdata;
        logic [RUN_AW-1:0] raddr;
    } ram_req_t;

endpackage

[rtl/axd_run_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axd_run_ram
// Run table: entry number and byte count of each stored run. One write port,
// one read port, registered read data.
// ----------------------------------------------------------------------------
module axd_run_ram
    import axd_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output run_t     rd_data
);

    run_t mem [RUN_DEPTH];
    run_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/axd_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axd_parser
// Per-byte parse of header, index records and data area. Runs are written to
// the run table during the index and read back one run ahead during data.
// ----------------------------------------------------------------------------
module axd_parser
    import axd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_item_t  item,
    input  logic [7:0] xor_key,
    input  run_t      ram_rd_data,
    output ram_req_t  ram_req,
    output out_item_t result
);

    phase_t              phase_reg, phase_next;
    logic [7:0]          fcnt_reg, fcnt_next;
    logic [31:0]         acc_reg, acc_next;
    logic [31:0]         magic_reg, magic_next;
    logic [COUNT_W-1:0]  entries_reg, entries_next;
    logic [COUNT_W-1:0]  stored_reg, stored_next;
    logic [COUNT_W-1:0]  rptr_reg, rptr_next;
    logic [COUNT_W-1:0]  rptr_inc;
    logic [SIZE_W-1:0]   left_reg, left_next;
    logic [SIZE_W-1:0]   left_dec;
    logic [3:0]          short_reg, short_next;
    status_t             err_reg, err_next;
    logic [ENTRY_W-1:0]  cur_entry_reg, cur_entry_next;
    run_t                first_run_reg, first_run_next;

    logic [7:0]  b;
    logic [31:0] acc_shift;
    logic [7:0]  fcnt_inc;

    assign b         = item.stream_byte ^ xor_key;
    assign acc_shift = {b, acc_reg[31:8]};
    assign fcnt_inc  = fcnt_reg + 8'd1;
    assign left_dec  = left_reg - 1'b1;
    assign rptr_inc  = rptr_reg + 1'b1;

    always_comb
    begin
        phase_next     = phase_reg;
        fcnt_next      = fcnt_reg;
        acc_next       = acc_reg;
        magic_next     = magic_reg;
        entries_next   = entries_reg;
        stored_next    = stored_reg;
        rptr_next      = rptr_reg;
        left_next      = left_reg;
        short_next     = short_reg;
        err_next       = err_reg;
        cur_entry_next = cur_entry_reg;
        first_run_next = first_run_reg;

        ram_req.we          = 1'b0;
        ram_req.waddr       = stored_reg[RUN_AW-1:0];
        ram_req.wdata.entry = ENTRY_W'(entries_reg);
        ram_req.wdata.size  = acc_shift;

        result.byte_kind    = KIND_IGNORED;
        result.decoded_byte = b;
        result.entry_number = '0;
        result.entry_final  = 1'b0;
        result.status       = ST_RUNNING;

        if (accept)
        begin
            if (short_reg < MIN_STREAM_BYTES)
            begin
                short_next = short_reg + 4'd1;
            end

            case (phase_reg)
                PH_HEADER:
                begin
                    result.byte_kind = KIND_HEADER;
                    acc_next  = acc_shift;
                    fcnt_next = fcnt_inc;
                    if (fcnt_inc == MAGIC_BYTES)
                    begin
                        magic_next = acc_shift;
                    end
                    if (fcnt_inc == HEADER_BYTES)
                    begin
                        fcnt_next = '0;
                        if (magic_reg != ARCHIVE_MAGIC || acc_shift != ARCHIVE_VERSION)
                        begin
                            err_next   = ST_HEADER_BAD;
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            phase_next = PH_FLAG;
                        end
                    end
                end
                PH_FLAG:
                begin
                    result.byte_kind = KIND_INDEX;
                    if (b != 8'd0)
                    begin
                        // run 0 comes from its own register; the RAM is read one ahead
                        phase_next     = PH_DATA;
                        rptr_next      = '0;
                        cur_entry_next = first_run_reg.entry;
                        left_next      = (stored_reg != '0) ? first_run_reg.size : '0;
                    end
                    else if (entries_reg >= COUNT_W'(MAX_ENTRIES))
                    begin
                        err_next   = ST_OVERFLOW;
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        phase_next = PH_NAMELEN;
                    end
                end
                PH_NAMELEN:
                begin
                    result.byte_kind = KIND_INDEX;
                    fcnt_next  = b;
                    phase_next = (b == 8'd0) ? PH_SIZE : PH_NAME;
                end
                PH_NAME:
                begin
                    result.byte_kind    = KIND_NAME;
                    result.entry_number = ENTRY_W'(entries_reg);
                    fcnt_next = fcnt_reg - 8'd1;
                    if (fcnt_reg == 8'd1)
                    begin
                        phase_next = PH_SIZE;
                    end
                end
                PH_SIZE:
                begin
                    result.byte_kind = KIND_INDEX;
                    acc_next  = acc_shift;
                    fcnt_next = fcnt_inc;
                    if (fcnt_inc == SIZE_BYTES)
                    begin
                        fcnt_next  = '0;
                        phase_next = PH_TIME;
                        if (acc_shift != '0 && stored_reg < COUNT_W'(MAX_ENTRIES))
                        begin
                            ram_req.we  = 1'b1;
                            stored_next = stored_reg + 1'b1;
                            if (stored_reg == '0)
                            begin
                                first_run_next = ram_req.wdata;
                            end
                        end
                    end
                end
                PH_TIME:
                begin
                    result.byte_kind = KIND_INDEX;
                    fcnt_next = fcnt_inc;
                    if (fcnt_inc == TIME_BYTES)
                    begin
                        fcnt_next    = '0;
                        entries_next = entries_reg + 1'b1;
                        phase_next   = PH_FLAG;
                    end
                end
                PH_DATA:
                begin
                    if (rptr_reg < stored_reg)
                    begin
                        result.byte_kind    = KIND_DATA;
                        result.entry_number = cur_entry_reg;
                        left_next = left_dec;
                        if (left_dec == '0)
                        begin
                            result.entry_final = 1'b1;
                            rptr_next      = rptr_inc;
                            left_next      = ram_rd_data.size;
                            cur_entry_next = ram_rd_data.entry;
                        end
                    end
                    else
                    begin
                        err_next   = ST_LENGTH;
                        phase_next = PH_ERROR;
                    end
                end
                default:
                begin
                    result.byte_kind = KIND_IGNORED;
                end
            endcase

            if (!item.stream_end)
            begin
                result.status = err_next;
            end
            else
            begin
                if (short_next < MIN_STREAM_BYTES)
                begin
                    result.status = ST_TRUNCATED;
                end
                else if (err_next != ST_RUNNING)
                begin
                    result.status = err_next;
                end
                else if (phase_next != PH_DATA)
                begin
                    result.status = ST_TRUNCATED;
                end
                else if (rptr_next < stored_next)
                begin
                    result.status = ST_LENGTH;
                end
                else
                begin
                    result.status = ST_OK;
                end

                phase_next   = PH_HEADER;
                fcnt_next    = '0;
                acc_next     = '0;
                magic_next   = '0;
                entries_next = '0;
                stored_next  = '0;
                rptr_next    = '0;
                left_next    = '0;
                short_next   = '0;
                err_next     = ST_RUNNING;
            end
        end

        // read the run after the one that will be current next cycle
        ram_req.raddr = RUN_AW'(rptr_next + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            fcnt_reg    <= '0;
            acc_reg     <= '0;
            magic_reg   <= '0;
            entries_reg <= '0;
            stored_reg  <= '0;
            rptr_reg    <= '0;
            left_reg    <= '0;
            short_reg   <= '0;
            err_reg     <= ST_RUNNING;
        end
        else
        begin
            phase_reg   <= phase_next;
            fcnt_reg    <= fcnt_next;
            acc_reg     <= acc_next;
            magic_reg   <= magic_next;
            entries_reg <= entries_next;
            stored_reg  <= stored_next;
            rptr_reg    <= rptr_next;
            left_reg    <= left_next;
            short_reg   <= short_next;
            err_reg     <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_entry_reg <= cur_entry_next;
        first_run_reg <= first_run_next;
    end

endmodule

[rtl/axd_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axd_out_buf
// Two-deep output buffer: output register plus skid register, so a new
// request is taken while a finished result waits.
// ----------------------------------------------------------------------------
module axd_out_buf
    import axd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_data,
    output logic      can_push,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_reg, out_next;
    out_item_t skid_reg, skid_next;
    logic      pop;

    assign pop      = out_valid_reg && out_ready;
    assign can_push = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

[rtl/xor_archive_stream_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_archive_stream_deframer
// Decodes an XOR-keyed archive byte stream into header, index and per-entry
// data bytes, with end-of-stream status.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while in_ready is high and gives exactly one
// result per byte; each result is registered in the output register, or in the
// skid register while an earlier result waits. A two-entry output buffer keeps
// input flowing while a result waits, so the rate is one byte per cycle
// whenever the consumer keeps out_ready high. Run sizes live in a 256 x 40 run
// table RAM that is read one run ahead, so even back-to-back one-byte entries
// need no stall; the table needs no clearing pass after reset. The key register
// must only be written while the block is idle.
// ----------------------------------------------------------------------------
module xor_archive_stream_deframer
    import axd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic [7:0] xor_key_reg;
    logic       accept;
    ram_req_t   ram_req;
    run_t       ram_rd_data;
    out_item_t  result;
    logic       can_push;

    assign in_ready = can_push;
    assign accept   = in_valid && can_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_key_reg <= KEY_RESET;
        end
        else if (cfg_wr_en)
        begin
            xor_key_reg <= cfg_wr_data;
        end
    end

    axd_run_ram u_run_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    axd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (in_item),
        .xor_key     (xor_key_reg),
        .ram_rd_data (ram_rd_data),
        .ram_req     (ram_req),
        .result      (result)
    );

    axd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
